>>> rtl/pvs_pkg.sv
// shared types and constants of the polyline simplifier
package pvs_pkg;

    localparam int WAVE_W  = 24;
    localparam int LEVEL_W = 32;
    localparam int SLOPE_W = 48;
    localparam int ST_W    = 2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_ORDER = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

    // one request from the front to the back
    typedef struct packed {
        logic               store;
        logic               run;
        logic [ST_W-1:0]    err;
        logic [WAVE_W-1:0]  w;
        logic [LEVEL_W-1:0] l;
    } t_cmd;

endpackage

>>> rtl/pvs_front.sv
// input side: point counting, order and overflow checks, request building
module pvs_front #(
    parameter int MAX_POINTS = 64,
    parameter int AW         = 6,
    parameter int CW         = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [pvs_pkg::WAVE_W-1:0]   i_w,
    input  logic [pvs_pkg::LEVEL_W-1:0]  i_l,
    input  logic                         i_last,
    input  logic                         i_q_full,
    output logic                         o_push,
    output pvs_pkg::t_cmd                o_cmd,
    output logic [AW-1:0]                o_idx,
    output logic [CW-1:0]                o_n
);
    import pvs_pkg::*;

    logic [CW-1:0]     r_cnt, n_cnt;
    logic [ST_W-1:0]   r_err, n_err;
    logic [WAVE_W-1:0] r_prev;
    logic              acc, full, bad;
    logic [ST_W-1:0]   err_now;
    logic [CW-1:0]     cnt_now;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && !i_q_full;
    assign full    = r_cnt >= CW'(MAX_POINTS);
    assign bad     = (i_w == '0) || ((r_cnt != '0) && (i_w <= r_prev));

    always_comb begin
        err_now = r_err;
        if (r_err == ST_OK) begin
            if (full) begin
                err_now = ST_FULL;
            end else if (bad) begin
                err_now = ST_ORDER;
            end
        end
        cnt_now = full ? r_cnt : r_cnt + CW'(1);
        n_cnt = r_cnt;
        n_err = r_err;
        if (acc) begin
            if (i_last) begin
                n_cnt = '0;
                n_err = ST_OK;
            end else begin
                n_cnt = cnt_now;
                n_err = err_now;
            end
        end
    end

    assign o_push    = acc && (!full || i_last);
    assign o_cmd.store = !full;
    assign o_cmd.run   = i_last;
    assign o_cmd.err   = err_now;
    assign o_cmd.w     = i_w;
    assign o_cmd.l     = i_l;
    assign o_idx     = r_cnt[AW-1:0];
    assign o_n       = cnt_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_err <= ST_OK;
        end else begin
            r_cnt <= n_cnt;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !full) begin
            r_prev <= i_w;
        end
    end

endmodule

>>> rtl/pvs_queue.sv
// short request queue between front and back
module pvs_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_pop
);
    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_count;
    logic          do_push, do_pop;

    assign o_full  = r_count == (PW+1)'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            r_count <= r_count + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> rtl/pvs_back.sv
// point store, vertex count dynamic program, slope divider and result output
module pvs_back #(
    parameter int MAX_POINTS      = 64,
    parameter int SLOPE_FRAC_BITS = 24,
    parameter int AW              = 6,
    parameter int CW              = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    output logic                         o_q_pop,
    input  pvs_pkg::t_cmd                i_cmd,
    input  logic [AW-1:0]                i_idx,
    input  logic [CW-1:0]                i_n,
    input  logic [pvs_pkg::LEVEL_W-1:0]  i_max_error,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [pvs_pkg::WAVE_W-1:0]   o_w,
    output logic [pvs_pkg::LEVEL_W-1:0]  o_l,
    output logic                         o_last,
    output logic                         o_red,
    output logic [pvs_pkg::ST_W-1:0]     o_status
);
    import pvs_pkg::*;

    localparam int DW  = SLOPE_FRAC_BITS + 25;
    localparam int QW  = (DW > SLOPE_W) ? DW : SLOPE_W + 1;
    localparam int DCW = $clog2(DW);
    localparam int XW  = LEVEL_W + 2;
    localparam logic [QW-1:0] LIM_POS = QW'(SLOPE_MAX);
    localparam logic [QW-1:0] LIM_NEG = QW'(SLOPE_MAX) + QW'(1);

    typedef enum logic [18:0] {
        S_IDLE     = 19'h00001,
        S_INIT     = 19'h00002,
        S_BSTART   = 19'h00004,
        S_BWAIT    = 19'h00008,
        S_ERD      = 19'h00010,
        S_EWAIT    = 19'h00020,
        S_DSET     = 19'h00040,
        S_DIV      = 19'h00080,
        S_DDONE    = 19'h00100,
        S_UPD      = 19'h00200,
        S_DEC_RD   = 19'h00400,
        S_DEC_WAIT = 19'h00800,
        S_BT_RD    = 19'h01000,
        S_BT_WAIT  = 19'h02000,
        S_EM_LIST  = 19'h04000,
        S_EM_LWAIT = 19'h08000,
        S_EM_RD    = 19'h10000,
        S_EM_OUT   = 19'h20000,
        S_EM_ERR   = 19'h40000
    } t_state;

    // memories
    logic [WAVE_W-1:0]  r_wave_mem  [MAX_POINTS];
    logic [LEVEL_W-1:0] r_level_mem [MAX_POINTS];
    logic [CW-1:0]      r_vc_mem    [MAX_POINTS];
    logic [AW-1:0]      r_pred_mem  [MAX_POINTS];
    logic [AW-1:0]      r_list_mem  [MAX_POINTS];
    logic [WAVE_W-1:0]  wave_q;
    logic [LEVEL_W-1:0] level_q;
    logic [CW-1:0]      vc_q;
    logic [AW-1:0]      pred_q, list_q;
    logic [AW-1:0]      wl_addr, vc_addr;
    logic               vc_we, pred_we, list_we;
    logic [AW-1:0]      vc_wa, pred_wa, list_wa;
    logic [CW-1:0]      vc_wd;
    logic [AW-1:0]      pred_wd;

    t_state r_state, n_state;
    logic [CW-1:0]  r_n, n_n, r_k, n_k, r_cnt, n_cnt, r_vcb, n_vcb, r_vce, n_vce;
    logic [AW-1:0]  r_b, n_b, r_e, n_e, r_idx, n_idx;
    logic           r_red, n_red, r_neg, n_neg;
    logic [ST_W-1:0] r_err, n_err;
    logic [WAVE_W-1:0]  r_wb, n_wb, r_run, n_run;
    logic [LEVEL_W-1:0] r_lb, n_lb;
    logic signed [XW-1:0] r_rise, n_rise;
    logic [1:0]     r_sel, n_sel;
    logic [DW-1:0]  r_dvd, n_dvd, r_q, n_q;
    logic [WAVE_W-1:0] r_rem, n_rem;
    logic [DCW-1:0] r_dcnt, n_dcnt;
    logic signed [SLOPE_W-1:0] r_s0, n_s0, r_s1, n_s1, r_s2, n_s2;
    logic signed [SLOPE_W-1:0] r_low, n_low, r_high, n_high;

    logic                 r_ov, n_ov;
    logic [WAVE_W-1:0]    r_ow, n_ow;
    logic [LEVEL_W-1:0]   r_ol, n_ol;
    logic                 r_olast, n_olast, r_ored, n_ored;
    logic [ST_W-1:0]      r_ost, n_ost;

    // combinational helpers
    logic                 out_free;
    logic [CW-1:0]        n_m1;
    logic [CW-1:0]        k_m1;
    logic [WAVE_W-1:0]    run_d;
    logic signed [XW-1:0] x_sel, me_x;
    logic [XW-1:0]        mag;
    logic [WAVE_W:0]      t_div, t_sub;
    logic                 ge;
    logic [QW-1:0]        qe;
    logic signed [SLOPE_W-1:0] sat;
    logic                 take;
    logic signed [SLOPE_W-1:0] lo_new, hi_new;
    logic                 em_last;

    assign out_free = !r_ov || i_ready;
    assign n_m1     = r_n - CW'(1);
    assign k_m1     = r_k - CW'(1);
    assign run_d    = wave_q - r_wb;
    assign me_x     = $signed({2'b00, i_max_error});
    assign x_sel    = (r_sel == 2'd0) ? r_rise :
                      (r_sel == 2'd1) ? r_rise - me_x : r_rise + me_x;
    assign mag      = x_sel[XW-1] ? XW'(-x_sel) : XW'(x_sel);
    assign t_div    = {r_rem, r_dvd[DW-1]};
    assign t_sub    = t_div - {1'b0, r_run};
    assign ge       = t_div >= {1'b0, r_run};
    assign qe       = QW'(r_q);
    assign take     = (r_s0 >= r_low) && (r_s0 <= r_high) &&
                      ({1'b0, r_vcb} + (CW+1)'(1) <= {1'b0, r_vce});
    assign lo_new   = (r_s1 > r_low) ? r_s1 : r_low;
    assign hi_new   = (r_s2 < r_high) ? r_s2 : r_high;
    assign em_last  = r_k == (r_cnt - CW'(1));

    // truncated quotient with sign applied and saturation
    always_comb begin
        if (r_neg) begin
            sat = (qe > LIM_NEG) ? SLOPE_MIN : SLOPE_W'(-qe);
        end else begin
            sat = (qe > LIM_POS) ? SLOPE_MAX : SLOPE_W'(qe);
        end
    end

    always_comb begin
        case (r_state)
            S_BSTART: wl_addr = r_b;
            S_ERD:    wl_addr = r_e;
            default:  wl_addr = r_idx;
        endcase
        case (r_state)
            S_BSTART: vc_addr = r_b;
            S_ERD:    vc_addr = r_e;
            default:  vc_addr = n_m1[AW-1:0];
        endcase
    end

    always_comb begin
        vc_we   = 1'b0;
        vc_wa   = r_e;
        vc_wd   = r_n;
        pred_we = 1'b0;
        pred_wa = r_e;
        pred_wd = r_b;
        list_we = (r_state == S_BT_RD);
        list_wa = k_m1[AW-1:0];
        if (r_state == S_INIT) begin
            vc_we = 1'b1;
            if (r_e == '0) begin
                vc_wd   = CW'(1);
                pred_we = 1'b1;
                pred_wd = '0;
            end
        end else if (r_state == S_UPD && take) begin
            vc_we   = 1'b1;
            vc_wd   = r_vcb + CW'(1);
            pred_we = 1'b1;
        end
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_cmd.store) begin
            r_wave_mem[i_idx]  <= i_cmd.w;
            r_level_mem[i_idx] <= i_cmd.l;
        end
        if (vc_we) begin
            r_vc_mem[vc_wa] <= vc_wd;
        end
        if (pred_we) begin
            r_pred_mem[pred_wa] <= pred_wd;
        end
        if (list_we) begin
            r_list_mem[list_wa] <= r_idx;
        end
        wave_q  <= r_wave_mem[wl_addr];
        level_q <= r_level_mem[wl_addr];
        vc_q    <= r_vc_mem[vc_addr];
        pred_q  <= r_pred_mem[r_idx];
        list_q  <= r_list_mem[r_k[AW-1:0]];
    end

    always_comb begin
        n_state = r_state;
        n_n = r_n;     n_k = r_k;     n_cnt = r_cnt; n_vcb = r_vcb; n_vce = r_vce;
        n_b = r_b;     n_e = r_e;     n_idx = r_idx; n_red = r_red; n_neg = r_neg;
        n_err = r_err; n_wb = r_wb;   n_run = r_run; n_lb = r_lb;   n_rise = r_rise;
        n_sel = r_sel; n_dvd = r_dvd; n_q = r_q;     n_rem = r_rem; n_dcnt = r_dcnt;
        n_s0 = r_s0;   n_s1 = r_s1;   n_s2 = r_s2;   n_low = r_low; n_high = r_high;
        n_ov = r_ov && !i_ready;
        n_ow = r_ow;   n_ol = r_ol;   n_olast = r_olast; n_ored = r_ored; n_ost = r_ost;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && i_cmd.run) begin
                    if (i_cmd.err != ST_OK) begin
                        n_err   = i_cmd.err;
                        n_state = S_EM_ERR;
                    end else begin
                        n_n = i_n;
                        if (i_n > CW'(2)) begin
                            n_e     = '0;
                            n_state = S_INIT;
                        end else begin
                            n_red   = 1'b0;
                            n_cnt   = i_n;
                            n_k     = '0;
                            n_state = S_EM_LIST;
                        end
                    end
                end
            end
            S_INIT: begin
                if (CW'(r_e) == n_m1) begin
                    n_b     = '0;
                    n_state = S_BSTART;
                end else begin
                    n_e = r_e + AW'(1);
                end
            end
            S_BSTART: n_state = S_BWAIT;
            S_BWAIT: begin
                n_wb    = wave_q;
                n_lb    = level_q;
                n_vcb   = vc_q;
                n_e     = r_b + AW'(1);
                n_low   = SLOPE_MIN;
                n_high  = SLOPE_MAX;
                n_state = S_ERD;
            end
            S_ERD: n_state = S_EWAIT;
            S_EWAIT: begin
                n_run   = (run_d == '0) ? WAVE_W'(1) : run_d;
                n_rise  = $signed({2'b00, level_q}) - $signed({2'b00, r_lb});
                n_vce   = vc_q;
                n_sel   = 2'd0;
                n_state = S_DSET;
            end
            S_DSET: begin
                n_neg   = x_sel[XW-1];
                n_dvd   = DW'(mag[XW-2:0]) << (SLOPE_FRAC_BITS - 8);
                n_rem   = '0;
                n_q     = '0;
                n_dcnt  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                // one quotient bit per cycle
                n_rem = ge ? t_sub[WAVE_W-1:0] : t_div[WAVE_W-1:0];
                n_q   = {r_q[DW-2:0], ge};
                n_dvd = r_dvd << 1;
                if (r_dcnt == DCW'(DW - 1)) begin
                    n_state = S_DDONE;
                end else begin
                    n_dcnt = r_dcnt + DCW'(1);
                end
            end
            S_DDONE: begin
                case (r_sel)
                    2'd0:    n_s0 = sat;
                    2'd1:    n_s1 = sat;
                    default: n_s2 = sat;
                endcase
                if (r_sel == 2'd2) begin
                    n_state = S_UPD;
                end else begin
                    n_sel   = r_sel + 2'd1;
                    n_state = S_DSET;
                end
            end
            S_UPD: begin
                n_low  = lo_new;
                n_high = hi_new;
                // empty corridor or last end point closes this start point
                if ((lo_new > hi_new) || (CW'(r_e) == n_m1)) begin
                    if (CW'(r_b) == n_m1 - CW'(1)) begin
                        n_state = S_DEC_RD;
                    end else begin
                        n_b     = r_b + AW'(1);
                        n_state = S_BSTART;
                    end
                end else begin
                    n_e     = r_e + AW'(1);
                    n_state = S_ERD;
                end
            end
            S_DEC_RD: n_state = S_DEC_WAIT;
            S_DEC_WAIT: begin
                if (vc_q < r_n) begin
                    n_red   = 1'b1;
                    n_cnt   = vc_q;
                    n_k     = vc_q;
                    n_idx   = n_m1[AW-1:0];
                    n_state = S_BT_RD;
                end else begin
                    n_red   = 1'b0;
                    n_cnt   = r_n;
                    n_k     = '0;
                    n_state = S_EM_LIST;
                end
            end
            S_BT_RD: begin
                n_k     = r_k - CW'(1);
                n_state = S_BT_WAIT;
            end
            S_BT_WAIT: begin
                n_idx   = pred_q;
                n_state = (r_k == '0) ? S_EM_LIST : S_BT_RD;
            end
            S_EM_LIST: n_state = S_EM_LWAIT;
            S_EM_LWAIT: begin
                n_idx   = r_red ? list_q : r_k[AW-1:0];
                n_state = S_EM_RD;
            end
            S_EM_RD: n_state = S_EM_OUT;
            S_EM_OUT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ow    = wave_q;
                    n_ol    = level_q;
                    n_olast = em_last;
                    n_ored  = r_red;
                    n_ost   = ST_OK;
                    n_k     = r_k + CW'(1);
                    n_state = em_last ? S_IDLE : S_EM_LIST;
                end
            end
            S_EM_ERR: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ow    = '0;
                    n_ol    = '0;
                    n_olast = 1'b1;
                    n_ored  = 1'b0;
                    n_ost   = r_err;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_low   <= SLOPE_MIN;
            r_high  <= SLOPE_MAX;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_low   <= n_low;
            r_high  <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;     r_k <= n_k;     r_cnt <= n_cnt; r_vcb <= n_vcb; r_vce <= n_vce;
        r_b <= n_b;     r_e <= n_e;     r_idx <= n_idx; r_red <= n_red; r_neg <= n_neg;
        r_err <= n_err; r_wb <= n_wb;   r_run <= n_run; r_lb <= n_lb;   r_rise <= n_rise;
        r_sel <= n_sel; r_dvd <= n_dvd; r_q <= n_q;     r_rem <= n_rem; r_dcnt <= n_dcnt;
        r_s0 <= n_s0;   r_s1 <= n_s1;   r_s2 <= n_s2;
        r_ow <= n_ow;   r_ol <= n_ol;   r_olast <= n_olast; r_ored <= n_ored;
        r_ost <= n_ost;
    end

    assign o_valid  = r_ov;
    assign o_w      = r_ow;
    assign o_l      = r_ol;
    assign o_last   = r_olast;
    assign o_red    = r_ored;
    assign o_status = r_ost;

`ifndef SYNTHESIS
    a_end_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> (r_e > r_b))
        else $error("end point not after start point");
    a_run_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_run != '0))
        else $error("divider started with zero run");
    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM_OUT) |-> (r_k < r_cnt))
        else $error("result index past kept count");
`endif

endmodule

>>> rtl/polyline_min_vertex_simplifier_core.sv
// top level of the minimum vertex polyline simplifier
// Usage:
//  s_axis carries one point per request: tdata holds wavelength (Q16.8) and
//  level (Q16.16), tlast marks the last point of the polyline and starts work.
//  m_axis returns the kept points in order; tlast marks the last one, tuser
//  holds the reduced flag and the status code (nonzero: one error result).
//  i_cfg_we writes the value tolerance (Q16.16); write it only while idle.
//  Points are taken at one per cycle, while the queue has room, into a four
//  entry request queue and written into the point store while the back end is
//  idle. After the last point of a good run of more than two points the vertex
//  counts are cleared, then start/end pairs are scanned, each pair with three
//  serial slope divisions of SLOPE_FRAC_BITS+25 quotient bits. A run of n
//  points costs up to n*(n-1)/2 pairs; an empty corridor ends the scan of a
//  start point early. Backtracking a reduced run follows the predecessor of
//  each kept point, and each emitted point is read out and then presented.
//  Runs are processed one after another.
//  A stalled receiver holds the output register; once the queue fills,
//  s_axis_tready drops. Reset clears the queue, counters and output valid,
//  and sets the tolerance to zero; no memory clearing is needed.
module polyline_min_vertex_simplifier_core #(
    parameter int MAX_POINTS      = 64,
    parameter int SLOPE_FRAC_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // wavelength[23:0], level[55:24]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_wavelength[23:0], out_level[55:24]
    output logic        m_axis_tlast,
    output logic [2:0]  m_axis_tuser    // reduced[0], status[2:1]
);
    import pvs_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int QDW = $bits(t_cmd) + AW + CW;

    logic [LEVEL_W-1:0] r_max_error;
    logic               push, q_full, q_valid, q_pop;
    t_cmd               f_cmd, b_cmd;
    logic [AW-1:0]      f_idx, b_idx;
    logic [CW-1:0]      f_n, b_n;
    logic [QDW-1:0]     q_out;
    logic [WAVE_W-1:0]  out_w;
    logic [LEVEL_W-1:0] out_l;
    logic               out_red;
    logic [ST_W-1:0]    out_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_error <= '0;
        end else if (i_cfg_we) begin
            r_max_error <= i_cfg_wdata;
        end
    end

    pvs_front #(.MAX_POINTS(MAX_POINTS), .AW(AW), .CW(CW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_w      (s_axis_tdata[23:0]),
        .i_l      (s_axis_tdata[55:24]),
        .i_last   (s_axis_tlast),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (f_cmd),
        .o_idx    (f_idx),
        .o_n      (f_n)
    );

    pvs_queue #(.W(QDW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_idx, f_n}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    assign {b_cmd, b_idx, b_n} = q_out;

    pvs_back #(
        .MAX_POINTS      (MAX_POINTS),
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS),
        .AW              (AW),
        .CW              (CW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_cmd       (b_cmd),
        .i_idx       (b_idx),
        .i_n         (b_n),
        .i_max_error (r_max_error),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_w         (out_w),
        .o_l         (out_l),
        .o_last      (m_axis_tlast),
        .o_red       (out_red),
        .o_status    (out_st)
    );

    assign m_axis_tdata = {out_l, out_w};
    assign m_axis_tuser = {out_st, out_red};

endmodule

>>> bench/tb_top.sv
// self-checking testbench for the minimum vertex polyline simplifier core
module tb_top;
    import pvs_pkg::*;

    localparam int     NPTS      = 64;
    localparam int     RAND_REQS = 230;
    localparam longint CYC_LIMIT = 6000000;
    localparam longint SAT_HI    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT_LO    = -SAT_HI - 1;

    typedef struct {
        logic [WAVE_W-1:0]  w;
        logic [LEVEL_W-1:0] l;
        bit                 last;
        bit                 red;
        logic [ST_W-1:0]    st;
    } t_kept_pt;

    typedef struct {
        logic [WAVE_W-1:0]  w;
        logic [LEVEL_W-1:0] l;
        bit                 last;
        bit                 typed;
        logic [ST_W-1:0]    st;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [55:0] s_data;
    logic        s_last;
    logic        m_valid;
    logic        m_ready;
    logic [55:0] m_data;
    logic        m_last;
    logic [2:0]  m_user;

    t_kept_pt kept_q[$];
    int       n_bad;
    int       hold_left;
    bit       gaps_on;
    longint   cycles;

    // predictor copy of the point store and the tolerance
    logic [WAVE_W-1:0]  pw[NPTS];
    logic [LEVEL_W-1:0] pl[NPTS];
    int                 n_loaded;
    logic [ST_W-1:0]    run_err;
    logic [31:0]        tol;

    polyline_min_vertex_simplifier_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .s_axis_tvalid(s_valid),
        .s_axis_tready(s_ready),
        .s_axis_tdata (s_data),
        .s_axis_tlast (s_last),
        .m_axis_tvalid(m_valid),
        .m_axis_tready(m_ready),
        .m_axis_tdata (m_data),
        .m_axis_tlast (m_last),
        .m_axis_tuser (m_user)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat_slope(longint rise, longint run);
        longint q;
        if (run == 0) run = 1;
        q = (rise * 65536) / run;
        if (q > SAT_HI) return SAT_HI;
        if (q < SAT_LO) return SAT_LO;
        return q;
    endfunction

    // stores one accepted point; on the last point works out the kept points
    task automatic simplify_point(input logic [WAVE_W-1:0] w, input logic [LEVEL_W-1:0] l,
                                  input bit last, input bit keep);
        int       vcnt[NPTS];
        int       prv[NPTS];
        longint   c_lo, c_hi, s, lo, hi, rise, run;
        int       n, m, idx, e;
        t_kept_pt r;
        t_kept_pt outv[$];
        if (n_loaded >= NPTS) begin
            if (run_err == ST_OK) run_err = ST_FULL;
        end else begin
            if (w == 0 || (n_loaded > 0 && w <= pw[n_loaded-1]))
                if (run_err == ST_OK) run_err = ST_ORDER;
            pw[n_loaded] = w;
            pl[n_loaded] = l;
            n_loaded++;
        end
        if (!last) return;
        n = n_loaded;
        if (run_err != ST_OK) begin
            r = '{w: '0, l: '0, last: 1'b1, red: 1'b0, st: run_err};
            outv = {outv, r};
        end else begin
            m = n;
            if (n > 2) begin
                for (int i = 0; i < n; i++) vcnt[i] = n;
                vcnt[0] = 1;
                prv[0]  = 0;
                for (int b = 0; b + 1 < n; b++) begin
                    c_lo = SAT_LO;
                    c_hi = SAT_HI;
                    e = b + 1;
                    while (e < n) begin
                        run  = longint'(pw[e]) - longint'(pw[b]);
                        rise = longint'(pl[e]) - longint'(pl[b]);
                        s  = sat_slope(rise, run);
                        lo = sat_slope(rise - longint'(tol), run);
                        hi = sat_slope(rise + longint'(tol), run);
                        if (s >= c_lo && s <= c_hi && vcnt[b] + 1 <= vcnt[e]) begin
                            vcnt[e] = vcnt[b] + 1;
                            prv[e]  = b;
                        end
                        if (lo > c_lo) c_lo = lo;
                        if (hi < c_hi) c_hi = hi;
                        if (c_lo > c_hi) e = n;
                        else e++;
                    end
                end
                if (vcnt[n-1] < n) m = 0;
            end
            if (m == 0) begin
                m   = vcnt[n-1];
                idx = n - 1;
                for (int k = m; k > 0; k--) begin
                    r = '{w: pw[idx], l: pl[idx], last: (k == m), red: 1'b1, st: ST_OK};
                    outv.push_front(r);
                    idx = prv[idx];
                end
            end else begin
                for (int k = 0; k < m; k++) begin
                    r = '{w: pw[k], l: pl[k], last: (k == m - 1), red: 1'b0, st: ST_OK};
                    outv = {outv, r};
                end
            end
        end
        n_loaded = 0;
        run_err  = ST_OK;
        if (keep) kept_q = {kept_q, outv};
    endtask

    // offers one request, with random idle cycles ahead of it when gaps are on
    task automatic send_point(input logic [WAVE_W-1:0] w, input logic [LEVEL_W-1:0] l,
                              input bit last, input bit keep);
        if (gaps_on) begin
            while ($urandom_range(99) < 24) begin
                s_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= {l, w};
        s_last  <= last;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        simplify_point(w, l, last, keep);
    endtask

    task automatic set_tol(input logic [31:0] v);
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (kept_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        tol = v;
    endtask

    // one polyline: kind 0 well formed, 1 order may be broken at one point, 2 zero wavelength
    task automatic send_run(input int n, input int kind);
        logic [WAVE_W-1:0]  w;
        logic [LEVEL_W-1:0] base_l, l;
        int unsigned        stp_max, namp, bad_at;
        int signed          dl;
        int                 lvl_mode;
        w = WAVE_W'(($urandom_range(3) == 0) ? $urandom_range(24'hF00000, 1)
                                              : $urandom_range(2000, 1));
        stp_max = (24'hFFFFFF - w) / (n + 1);
        if (stp_max == 0) stp_max = 1;
        if ($urandom_range(1) == 0 && stp_max > 255) stp_max = 255;
        base_l   = $urandom;
        dl       = $urandom_range(4000) - 2000;
        namp     = ($urandom_range(2) == 0) ? 0 : (1 << $urandom_range(20));
        lvl_mode = $urandom_range(4);
        bad_at   = $urandom_range(n - 1);
        for (int i = 0; i < n; i++) begin
            if (lvl_mode == 0) l = $urandom;
            else l = base_l + i * dl + $urandom_range(namp);
            if (kind == 1 && i == bad_at && i > 0) w = WAVE_W'(w - $urandom_range(1, 0));
            if (kind == 2 && i == bad_at) w = '0;
            send_point(w, l, i == n - 1, 1'b1);
            if (kind == 2 && i == bad_at) w = WAVE_W'(1);
            w = WAVE_W'(w + $urandom_range(stp_max, 1));
        end
    endtask

    task automatic check_result();
        t_kept_pt x;
        if (kept_q.size() == 0) begin
            n_bad++;
            if (n_bad <= 10)
                $display("unexpected result: w=%h l=%h last=%b user=%b", m_data[23:0],
                         m_data[55:24], m_last, m_user);
            return;
        end
        x = kept_q.pop_front();
        if (m_data[23:0] !== x.w || m_data[55:24] !== x.l || m_last !== x.last ||
            m_user[0] !== x.red || m_user[2:1] !== x.st) begin
            n_bad++;
            if (n_bad <= 10)
                $display("mismatch: exp w=%h l=%h last=%b red=%b st=%0d, got w=%h l=%h last=%b red=%b st=%0d",
                         x.w, x.l, x.last, x.red, x.st, m_data[23:0], m_data[55:24],
                         m_last, m_user[0], m_user[2:1]);
        end
    endtask

    // receiver: random back pressure plus a long hold-off when asked
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_valid && m_ready) check_result();
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(gaps_on && $urandom_range(99) < 24);
            end
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYC_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial begin
        t_dir_row dir_tab[20];
        int       sent, nrun, n, kind;
        logic [31:0] tv;
        dir_tab = '{
            '{24'd1,       32'd0,          0, 0, ST_OK},
            '{24'hFFFFFF,  32'hFFFFFFFF,   1, 0, ST_OK},
            '{24'd0,       32'd5,          1, 1, ST_ORDER},
            '{24'd100,     32'd0,          0, 0, ST_OK},
            '{24'd100,     32'd7,          1, 1, ST_ORDER},
            '{24'd300,     32'd1,          0, 0, ST_OK},
            '{24'd200,     32'd2,          1, 1, ST_ORDER},
            '{24'h800000,  32'h80000000,   1, 0, ST_OK},
            '{24'd100,     32'd0,          0, 0, ST_OK},
            '{24'd200,     32'd1000,       0, 0, ST_OK},
            '{24'd300,     32'd2000,       0, 0, ST_OK},
            '{24'd400,     32'd3000,       1, 0, ST_OK},
            '{24'd1,       32'd0,          0, 0, ST_OK},
            '{24'd2,       32'hFFFFFFFF,   0, 0, ST_OK},
            '{24'd3,       32'd0,          0, 0, ST_OK},
            '{24'd4,       32'hFFFFFFFF,   1, 0, ST_OK},
            '{24'd10,      32'd500,        0, 0, ST_OK},
            '{24'd20,      32'd600,        0, 0, ST_OK},
            '{24'd30,      32'd500,        0, 0, ST_OK},
            '{24'd40,      32'd600,        1, 0, ST_OK}
        };
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        s_last    = 1'b0;
        n_bad     = 0;
        hold_left = 0;
        gaps_on   = 1'b1;
        n_loaded  = 0;
        run_err   = ST_OK;
        tol       = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, tolerance still at its reset value
        foreach (dir_tab[i]) begin
            send_point(dir_tab[i].w, dir_tab[i].l, dir_tab[i].last, !dir_tab[i].typed);
            if (dir_tab[i].typed)
                kept_q = {kept_q, t_kept_pt'{w: '0, l: '0, last: 1'b1, red: 1'b0,
                                             st: dir_tab[i].st}};
        end

        // full store, then overflow by one and by several points
        set_tol(32'd0);
        send_run(NPTS, 0);
        set_tol(32'hFFFFFFFF);
        send_run(3, 0);
        send_run(NPTS + 1, 0);
        send_run(NPTS + 6, 1);
        set_tol(32'd4);

        sent = 0;
        nrun = 0;
        while (sent < RAND_REQS) begin
            if (nrun % 8 == 7) begin
                case ($urandom_range(3))
                    0: tv = 32'd0;
                    1: tv = 32'hFFFFFFFF;
                    2: tv = $urandom;
                    default: tv = $urandom_range(1 << 20);
                endcase
                set_tol(tv);
            end
            if (nrun == 20) hold_left = 3000;
            gaps_on = !(nrun >= 20 && nrun < 40);
            n    = ($urandom_range(9) == 0) ? $urandom_range(24, 13) : $urandom_range(12, 1);
            kind = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : 0;
            send_run(n, kind);
            sent += n;
            nrun++;
        end
        s_valid <= 1'b0;
        while (kept_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_bad == 0 && kept_q.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/pvs_pkg.sv
rtl/pvs_front.sv
rtl/pvs_queue.sv
rtl/pvs_back.sv
rtl/polyline_min_vertex_simplifier_core.sv
bench/tb_top.sv
